[hw/rtl/nct_pkg.sv]
package nct_pkg;

    // element fields carried by one transaction on either channel
    localparam int FIELD_COUNT = 6;

    localparam int DEF_VECTOR_LEN = 6;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int IDX_WIDTH = 3;

    typedef logic [IDX_WIDTH-1:0] t_idx;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_CAND = 1'b1;

endpackage

[hw/rtl/nct_lane.sv]
module nct_lane #(
    parameter int DATA_WIDTH = nct_pkg::DEF_DATA_WIDTH
) (
    input  logic [DATA_WIDTH-1:0] i_track,
    input  logic [DATA_WIDTH-1:0] i_cand,
    output logic [DATA_WIDTH-1:0] o_mag
);

    logic [DATA_WIDTH:0] w_diff;
    logic [DATA_WIDTH:0] w_abs;

    // exact difference one bit wider than the operands
    assign w_diff = {i_track[DATA_WIDTH-1], i_track} - {i_cand[DATA_WIDTH-1], i_cand};
    assign w_abs  = w_diff[DATA_WIDTH] ? (~w_diff + {{DATA_WIDTH{1'b0}}, 1'b1}) : w_diff;

    // magnitude never exceeds 2^DATA_WIDTH-1, so the top bit is always clear
    assign o_mag = w_abs[DATA_WIDTH-1:0];

endmodule

[hw/rtl/nct_max_tree.sv]
module nct_max_tree #(
    parameter int LANES      = nct_pkg::DEF_VECTOR_LEN,
    parameter int DATA_WIDTH = nct_pkg::DEF_DATA_WIDTH
) (
    input  logic [LANES-1:0][DATA_WIDTH-1:0] i_mag,
    output logic [DATA_WIDTH-1:0]            o_max
);

    localparam int LEAVES = (LANES > 1) ? (1 << $clog2(LANES)) : 1;

    // heap layout: node n has children 2n and 2n+1, leaves start at LEAVES
    logic [DATA_WIDTH-1:0] w_node [1:2*LEAVES-1];

    genvar l, n;
    generate
        for (l = 0; l < LEAVES; l++) begin : g_leaf
            if (l < LANES) begin : g_used
                assign w_node[LEAVES+l] = i_mag[l];
            end else begin : g_pad
                assign w_node[LEAVES+l] = '0;
            end
        end
        for (n = 1; n < LEAVES; n++) begin : g_node
            assign w_node[n] = (w_node[2*n] > w_node[2*n+1]) ? w_node[2*n] : w_node[2*n+1];
        end
    endgenerate

    assign o_max = w_node[1];

endmodule

[hw/rtl/nearest_candidate_tracker.sv]
// channel | valid      | ready       | payload
// --------+------------+-------------+-----------------------------------------------
// in      | i_in_valid | o_in_ready  | i_func, i_elem_0..5, i_cand_index, i_last_candidate
// out     | o_out_valid| i_out_ready | o_chosen_index, o_out_0..5, o_min_distance
//
// one transaction per cycle: the element lanes, the max tree and the best compare
// settle within the cycle the transaction is accepted, so a candidate right after
// a set's last one already sees the new tracked vector.
// the result sits in a one-deep output register; input stalls only while that
// register is full and i_out_ready is low.
// synchronous active-low reset clears the tracked vector and closes any open set.
module nearest_candidate_tracker #(
    parameter int VECTOR_LEN = nct_pkg::DEF_VECTOR_LEN,
    parameter int DATA_WIDTH = nct_pkg::DEF_DATA_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_func,
    input  logic signed [DATA_WIDTH-1:0]  i_elem_0,
    input  logic signed [DATA_WIDTH-1:0]  i_elem_1,
    input  logic signed [DATA_WIDTH-1:0]  i_elem_2,
    input  logic signed [DATA_WIDTH-1:0]  i_elem_3,
    input  logic signed [DATA_WIDTH-1:0]  i_elem_4,
    input  logic signed [DATA_WIDTH-1:0]  i_elem_5,
    input  nct_pkg::t_idx                 i_cand_index,
    input  logic                          i_last_candidate,

    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output nct_pkg::t_idx                 o_chosen_index,
    output logic signed [DATA_WIDTH-1:0]  o_out_0,
    output logic signed [DATA_WIDTH-1:0]  o_out_1,
    output logic signed [DATA_WIDTH-1:0]  o_out_2,
    output logic signed [DATA_WIDTH-1:0]  o_out_3,
    output logic signed [DATA_WIDTH-1:0]  o_out_4,
    output logic signed [DATA_WIDTH-1:0]  o_out_5,
    output logic        [DATA_WIDTH-1:0]  o_min_distance
);

    localparam int USED_LEN = (VECTOR_LEN < nct_pkg::FIELD_COUNT) ?
                              VECTOR_LEN : nct_pkg::FIELD_COUNT;

    logic [DATA_WIDTH-1:0] w_in  [nct_pkg::FIELD_COUNT];
    logic [DATA_WIDTH-1:0] w_out [nct_pkg::FIELD_COUNT];

    logic [USED_LEN-1:0][DATA_WIDTH-1:0] w_mag;
    logic [DATA_WIDTH-1:0]               w_dist;

    logic [DATA_WIDTH-1:0] r_track     [USED_LEN];
    logic [DATA_WIDTH-1:0] r_best      [USED_LEN];
    logic [DATA_WIDTH-1:0] r_best_dist;
    nct_pkg::t_idx         r_best_slot;
    logic                  r_set_open;

    logic [DATA_WIDTH-1:0] n_best      [USED_LEN];
    logic [DATA_WIDTH-1:0] n_best_dist;
    nct_pkg::t_idx         n_best_slot;

    logic                  r_out_valid;
    nct_pkg::t_idx         r_out_idx;
    logic [DATA_WIDTH-1:0] r_out_elem  [USED_LEN];
    logic [DATA_WIDTH-1:0] r_out_dist;

    logic w_fire;
    logic w_is_cand;
    logic w_emit;
    logic w_take;

    assign w_in[0] = i_elem_0;
    assign w_in[1] = i_elem_1;
    assign w_in[2] = i_elem_2;
    assign w_in[3] = i_elem_3;
    assign w_in[4] = i_elem_4;
    assign w_in[5] = i_elem_5;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_fire     = i_in_valid && o_in_ready;
    assign w_is_cand  = (i_func == nct_pkg::FUNC_CAND);
    assign w_emit     = w_fire && w_is_cand && i_last_candidate;

    genvar g;
    generate
        for (g = 0; g < USED_LEN; g++) begin : g_lane
            nct_lane #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_lane (
                .i_track (r_track[g]),
                .i_cand  (w_in[g]),
                .o_mag   (w_mag[g])
            );
        end
    endgenerate

    nct_max_tree #(
        .LANES      (USED_LEN),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_max_tree (
        .i_mag (w_mag),
        .o_max (w_dist)
    );

    // first candidate of a set always wins; ties go to the lower index
    assign w_take = !r_set_open || (w_dist < r_best_dist) ||
                    ((w_dist == r_best_dist) && (i_cand_index < r_best_slot));

    always_comb begin
        for (int k = 0; k < USED_LEN; k++) begin
            n_best[k] = w_take ? w_in[k] : r_best[k];
        end
        n_best_dist = w_take ? w_dist : r_best_dist;
        n_best_slot = w_take ? i_cand_index : r_best_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < USED_LEN; k++) begin
                r_track[k] <= '0;
            end
            r_best_dist <= '1;
            r_best_slot <= '0;
            r_set_open  <= 1'b0;
        end else if (w_fire) begin
            if (!w_is_cand) begin
                // load drops any open set
                for (int k = 0; k < USED_LEN; k++) begin
                    r_track[k] <= w_in[k];
                end
                r_best_dist <= '1;
                r_set_open  <= 1'b0;
            end else if (i_last_candidate) begin
                for (int k = 0; k < USED_LEN; k++) begin
                    r_track[k] <= n_best[k];
                end
                r_best_dist <= '1;
                r_best_slot <= n_best_slot;
                r_set_open  <= 1'b0;
            end else begin
                r_best_dist <= n_best_dist;
                r_best_slot <= n_best_slot;
                r_set_open  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_is_cand) begin
            for (int k = 0; k < USED_LEN; k++) begin
                r_best[k] <= n_best[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            for (int k = 0; k < USED_LEN; k++) begin
                r_out_elem[k] <= n_best[k];
            end
            r_out_idx  <= n_best_slot;
            r_out_dist <= n_best_dist;
        end
    end

    generate
        for (g = 0; g < nct_pkg::FIELD_COUNT; g++) begin : g_out
            if (g < USED_LEN) begin : g_used
                assign w_out[g] = r_out_elem[g];
            end else begin : g_zero
                assign w_out[g] = '0;
            end
        end
    endgenerate

    assign o_out_valid    = r_out_valid;
    assign o_chosen_index = r_out_idx;
    assign o_out_0        = w_out[0];
    assign o_out_1        = w_out[1];
    assign o_out_2        = w_out[2];
    assign o_out_3        = w_out[3];
    assign o_out_4        = w_out[4];
    assign o_out_5        = w_out[5];
    assign o_min_distance = r_out_dist;

endmodule

[tb/sv/tb_nearest_candidate_tracker.sv]
module tb_nearest_candidate_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VEC_LEN      = nct_pkg::DEF_VECTOR_LEN;
    localparam int RANDOM_ITEMS = 1530;
    localparam int DRAIN_EVERY  = 400;

    typedef logic [nct_pkg::FIELD_COUNT-1:0][31:0] t_elem_vec;

    typedef struct {
        logic          func;
        t_elem_vec     elems;
        nct_pkg::t_idx idx;
        logic          last;
    } t_cand_item;

    typedef struct {
        nct_pkg::t_idx idx;
        t_elem_vec     elems;
        logic [31:0]   min_dist;
    } t_chosen;

    typedef struct {
        t_cand_item    item;
        bit            typed;
        nct_pkg::t_idx exp_idx;
        logic [31:0]   exp_dist;
    } t_table_row;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_ready;
    logic          i_func;
    logic [31:0]   i_elem_0, i_elem_1, i_elem_2, i_elem_3, i_elem_4, i_elem_5;
    nct_pkg::t_idx i_cand_index;
    logic          i_last_candidate;
    logic          o_out_valid;
    logic          i_out_ready;
    nct_pkg::t_idx o_chosen_index;
    logic [31:0]   o_out_0, o_out_1, o_out_2, o_out_3, o_out_4, o_out_5;
    logic [31:0]   o_min_distance;

    nearest_candidate_tracker u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_elem_0         (i_elem_0),
        .i_elem_1         (i_elem_1),
        .i_elem_2         (i_elem_2),
        .i_elem_3         (i_elem_3),
        .i_elem_4         (i_elem_4),
        .i_elem_5         (i_elem_5),
        .i_cand_index     (i_cand_index),
        .i_last_candidate (i_last_candidate),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_chosen_index   (o_chosen_index),
        .o_out_0          (o_out_0),
        .o_out_1          (o_out_1),
        .o_out_2          (o_out_2),
        .o_out_3          (o_out_3),
        .o_out_4          (o_out_4),
        .o_out_5          (o_out_5),
        .o_min_distance   (o_min_distance)
    );

    // tracker state mirrored on the testbench side
    t_elem_vec     trk_vec  = '0;
    t_elem_vec     best_vec = '0;
    logic [31:0]   best_dist = '1;
    nct_pkg::t_idx best_idx = '0;
    bit            set_busy = 1'b0;

    t_chosen     awaited_results[$];
    t_table_row  dir_table[$];

    int n_errors  = 0;
    int n_items   = 0;
    int n_loads   = 0;
    int n_dropped = 0;
    int n_checked = 0;
    bit no_stall  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("[nearest_candidate_tracker] ERROR");
        $finish;
    end

    function automatic bit track_candidate(input t_cand_item it, output t_chosen res);
        t_elem_vec          c;
        logic signed [32:0] diff;
        logic        [32:0] mag;
        logic        [31:0] worst;
        c = '0;
        for (int i = 0; i < nct_pkg::FIELD_COUNT; i++)
            if (i < VEC_LEN) c[i] = it.elems[i];
        res.idx      = '0;
        res.elems    = '0;
        res.min_dist = '0;
        if (it.func == nct_pkg::FUNC_LOAD) begin
            trk_vec   = c;
            set_busy  = 1'b0;
            best_dist = '1;
            return 1'b0;
        end
        // differences are exact in 33 bits, magnitude fits 32 unsigned bits
        worst = '0;
        for (int i = 0; i < VEC_LEN && i < nct_pkg::FIELD_COUNT; i++) begin
            diff = $signed({trk_vec[i][31], trk_vec[i]}) - $signed({c[i][31], c[i]});
            mag  = diff[32] ? -diff : diff;
            if (mag > 33'h0_ffff_ffff) mag = 33'h0_ffff_ffff;
            if (mag[31:0] > worst) worst = mag[31:0];
        end
        if (!set_busy || worst < best_dist || (worst == best_dist && it.idx < best_idx)) begin
            best_vec  = c;
            best_dist = worst;
            best_idx  = it.idx;
        end
        set_busy = 1'b1;
        if (!it.last) return 1'b0;
        res.idx      = best_idx;
        res.elems    = best_vec;
        res.min_dist = best_dist;
        trk_vec      = best_vec;
        set_busy     = 1'b0;
        best_dist    = '1;
        return 1'b1;
    endfunction

    function automatic t_table_row row(input logic f, input t_elem_vec e,
                                       input nct_pkg::t_idx x,
                                       input logic l, input bit typed = 1'b0,
                                       input nct_pkg::t_idx ei = '0,
                                       input logic [31:0] ed = '0);
        t_table_row r;
        r.item.func  = f;
        r.item.elems = e;
        r.item.idx   = x;
        r.item.last  = l;
        r.typed      = typed;
        r.exp_idx    = ei;
        r.exp_dist   = ed;
        return r;
    endfunction

    // mostly near the tracked vector on a coarse grid so distance ties are common
    function automatic t_elem_vec make_vec();
        t_elem_vec v;
        int        mode;
        int        sh;
        mode = $urandom_range(0, 9);
        case ($urandom_range(0, 3))
            0: sh = 0;
            1: sh = 16;
            2: sh = 24;
            default: sh = 27;
        endcase
        for (int i = 0; i < nct_pkg::FIELD_COUNT; i++) begin
            if (mode < 2) begin
                v[i] = $urandom;
            end else if (mode < 8) begin
                v[i] = trk_vec[i] + ((int'($urandom_range(0, 6)) - 3) <<< sh);
            end else begin
                case ($urandom_range(0, 3))
                    0: v[i] = 32'h8000_0000;
                    1: v[i] = 32'h7fff_ffff;
                    2: v[i] = 32'h0000_0000;
                    default: v[i] = 32'hffff_ffff;
                endcase
            end
        end
        return v;
    endfunction

    task automatic offer_item(input t_cand_item it, input bit typed, input t_chosen typed_res);
        t_chosen predicted;
        bit      got;
        while (!no_stall && $urandom_range(0, 99) < 7) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_func           <= it.func;
        i_elem_0         <= it.elems[0];
        i_elem_1         <= it.elems[1];
        i_elem_2         <= it.elems[2];
        i_elem_3         <= it.elems[3];
        i_elem_4         <= it.elems[4];
        i_elem_5         <= it.elems[5];
        i_cand_index     <= it.idx;
        i_last_candidate <= it.last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_items++;
        if (it.func == nct_pkg::FUNC_LOAD) begin
            n_loads++;
            if (set_busy) n_dropped++;
        end
        got = track_candidate(it, predicted);
        if (got) awaited_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    // result side: check against the oldest expectation, then pick next ready
    always @(posedge i_clk) begin : result_side
        t_chosen   want;
        t_elem_vec got_elems;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t unexpected result: index %0d distance %h",
                         $time, o_chosen_index, o_min_distance);
                n_errors++;
            end else begin
                want      = awaited_results.pop_front();
                got_elems = {o_out_5, o_out_4, o_out_3, o_out_2, o_out_1, o_out_0};
                n_checked++;
                if (o_chosen_index !== want.idx) begin
                    $display("%0t mismatch chosen_index: expected %0d, actual %0d",
                             $time, want.idx, o_chosen_index);
                    n_errors++;
                end
                for (int i = 0; i < nct_pkg::FIELD_COUNT; i++) begin
                    if (got_elems[i] !== want.elems[i]) begin
                        $display("%0t mismatch out_%0d: expected %h, actual %h",
                                 $time, i, want.elems[i], got_elems[i]);
                        n_errors++;
                    end
                end
                if (o_min_distance !== want.min_dist) begin
                    $display("%0t mismatch min_distance: expected %h, actual %h",
                             $time, want.min_dist, o_min_distance);
                    n_errors++;
                end
            end
        end
        if (!no_stall && $urandom_range(0, 99) < 7) i_out_ready <= 1'b0;
        else i_out_ready <= 1'b1;
    end

    initial begin : stimulus
        t_cand_item it;
        t_chosen    typed_res;
        t_table_row r;
        int         set_len;
        bit         ordered;
        int         drain_at;

        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_out_ready      <= 1'b0;
        i_func           <= nct_pkg::FUNC_LOAD;
        i_elem_0         <= '0;
        i_elem_1         <= '0;
        i_elem_2         <= '0;
        i_elem_3         <= '0;
        i_elem_4         <= '0;
        i_elem_5         <= '0;
        i_cand_index     <= '0;
        i_last_candidate <= 1'b0;

        // single-candidate sets from reset, including the all-ones distance
        dir_table.push_back(row(nct_pkg::FUNC_CAND, {6{32'h0000_0000}}, 3'd0, 1'b1,
                                1'b1, 3'd0, 32'h0000_0000));
        dir_table.push_back(row(nct_pkg::FUNC_CAND, {6{32'h8000_0000}}, 3'd7, 1'b1,
                                1'b1, 3'd7, 32'h8000_0000));
        dir_table.push_back(row(nct_pkg::FUNC_CAND, {6{32'h7fff_ffff}}, 3'd3, 1'b1,
                                1'b1, 3'd3, 32'hffff_ffff));
        dir_table.push_back(row(nct_pkg::FUNC_CAND, {6{32'h7fff_ffff}}, 3'd1, 1'b1,
                                1'b1, 3'd1, 32'h0000_0000));
        // load with last set, which must be ignored
        dir_table.push_back(row(nct_pkg::FUNC_LOAD, {6{32'h0000_0000}}, 3'd0, 1'b1));
        // distance ties: lower index wins, equal index keeps the earlier one
        dir_table.push_back(row(nct_pkg::FUNC_CAND, {6{32'h1000_0000}}, 3'd5, 1'b0));
        dir_table.push_back(row(nct_pkg::FUNC_CAND, {6{32'hf000_0000}}, 3'd2, 1'b0));
        dir_table.push_back(row(nct_pkg::FUNC_CAND, {6{32'h1000_0000}}, 3'd2, 1'b0));
        dir_table.push_back(row(nct_pkg::FUNC_CAND, {6{32'h1000_0000}}, 3'd6, 1'b0));
        dir_table.push_back(row(nct_pkg::FUNC_CAND,
                                {32'h0, 32'hf800_0000, 32'h0, 32'h0800_0000,
                                 32'hffff_ffff, 32'h0000_0001}, 3'd4, 1'b1));
        // alternating bit patterns, then a load that drops the open set
        dir_table.push_back(row(nct_pkg::FUNC_LOAD,
                                {3{32'haaaa_aaaa, 32'h5555_5555}}, 3'd7, 1'b0));
        dir_table.push_back(row(nct_pkg::FUNC_CAND,
                                {3{32'h5555_5555, 32'haaaa_aaaa}}, 3'd0, 1'b0));
        dir_table.push_back(row(nct_pkg::FUNC_LOAD, {6{32'h0000_0100}}, 3'd0, 1'b0));
        dir_table.push_back(row(nct_pkg::FUNC_CAND, {6{32'h0000_0100}}, 3'd4, 1'b1,
                                1'b1, 3'd4, 32'h0000_0000));
        // the largest lane difference moves from lane to lane
        dir_table.push_back(row(nct_pkg::FUNC_CAND,
                                {{5{32'h0000_0101}}, 32'h0000_0150}, 3'd0, 1'b0));
        dir_table.push_back(row(nct_pkg::FUNC_CAND,
                                {32'h0000_00d0, {5{32'h0000_0100}}}, 3'd1, 1'b0));
        dir_table.push_back(row(nct_pkg::FUNC_CAND, {{3{32'h0000_0100}}, 32'h0000_0130,
                                                     {2{32'h0000_0100}}}, 3'd2, 1'b0));
        dir_table.push_back(row(nct_pkg::FUNC_CAND, {{2{32'h0000_0100}}, 32'h0000_00d0,
                                                     {3{32'h0000_0100}}}, 3'd0, 1'b0));
        dir_table.push_back(row(nct_pkg::FUNC_CAND, {32'h0000_0100, 32'h0000_0160,
                                                     {4{32'h0000_0100}}}, 3'd5, 1'b1));
        // opposite extremes in every lane
        dir_table.push_back(row(nct_pkg::FUNC_LOAD,
                                {3{32'h7fff_ffff, 32'h8000_0000}}, 3'd0, 1'b0));
        dir_table.push_back(row(nct_pkg::FUNC_CAND,
                                {3{32'h8000_0000, 32'h7fff_ffff}}, 3'd7, 1'b1,
                                1'b1, 3'd7, 32'hffff_ffff));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[k]) begin
            r = dir_table[k];
            typed_res.idx      = r.exp_idx;
            typed_res.elems    = r.item.elems;
            typed_res.min_dist = r.exp_dist;
            offer_item(r.item, r.typed, typed_res);
        end
        drain_results();

        drain_at = DRAIN_EVERY;
        while (n_items < RANDOM_ITEMS + dir_table.size()) begin
            no_stall = (n_items >= 500 && n_items < 800);
            if (n_items >= drain_at) begin
                drain_results();
                drain_at += DRAIN_EVERY;
            end
            if ($urandom_range(0, 99) < 12) begin
                it.func  = nct_pkg::FUNC_LOAD;
                it.elems = make_vec();
                it.idx   = nct_pkg::t_idx'($urandom_range(0, 7));
                it.last  = 1'($urandom_range(0, 1));
                offer_item(it, 1'b0, typed_res);
            end else begin
                set_len = $urandom_range(1, 8);
                ordered = $urandom_range(0, 99) < 60;
                for (int k = 0; k < set_len; k++) begin
                    // occasional load breaks the set without a result
                    it.func  = ($urandom_range(0, 99) < 3) ? nct_pkg::FUNC_LOAD
                                                           : nct_pkg::FUNC_CAND;
                    it.elems = make_vec();
                    it.idx   = ordered ? nct_pkg::t_idx'(k)
                                       : nct_pkg::t_idx'($urandom_range(0, 7));
                    it.last  = (k == set_len - 1);
                    offer_item(it, 1'b0, typed_res);
                    if (it.func == nct_pkg::FUNC_LOAD) break;
                end
            end
        end
        no_stall = 1'b0;

        drain_results();
        repeat (5) @(posedge i_clk);

        $display("covered %0d transactions: %0d loads (%0d dropping an open set)",
                 n_items, n_loads, n_dropped);
        $display("checked %0d chosen candidates with random stalls on both channels",
                 n_checked);
        if (n_errors == 0 && awaited_results.size() == 0) begin
            $display("[nearest_candidate_tracker] OK");
        end else begin
            $display("[nearest_candidate_tracker] ERROR");
        end
        $finish;
    end

endmodule
